// File: design/va_pkg.sv
// Shared types, constants and helpers of the three-component vector ALU.
package va_pkg;

  // Component width and fixed-point fraction size.
  localparam int W         = 32;
  localparam int FRAC_BITS = 16;

  // One square-root stage per result bit, one divider stage per quotient bit.
  localparam int SQ_STEPS = W;
  localparam int DIV_W    = W + FRAC_BITS;

  // Cycles from the accepting edge to the edge that raises the result strobe.
  localparam int LATENCY = 4 + SQ_STEPS + DIV_W;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CROSS = 4'd2,
    OP_DOT   = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_EQUAL = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [2:0][W-1:0]    a;
    logic [W-1:0]         s;
    logic [2:0][W-1:0]    r;
    logic [W-1:0]         scalar;
    logic                 eq;
    logic                 sat;
    logic [2*W-1:0]       sq;
    logic [W-1:0]         root;
  } item_t;

  // Clamp a wide signed value to W bits; the top bit of the result is the saturation flag.
  function automatic logic [W:0] sat_w(input logic signed [2*W+1:0] v);
    logic signed [2*W+1:0] hi;
    logic signed [2*W+1:0] lo;
    hi = {{(W+3){1'b0}}, {(W-1){1'b1}}};
    lo = {{(W+3){1'b1}}, {(W-1){1'b0}}};
    if (v > hi) begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  // Magnitude of a signed component as an unsigned value (the most negative code fits).
  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: design/va_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
module va_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  va_pkg::item_t in_item,
  output va_pkg::item_t out_item
);
  import va_pkg::*;

  item_t      st [SQ_STEPS];
  logic [W:0] rm [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    item_t      cur;
    logic [W:0] cur_rm;
    item_t      nxt;
    logic [W:0] rm_next;
    logic [W+2:0] rem_sh;
    logic [W+2:0] trial;
    logic [W+2:0] diff;
    logic         take;

    if (k == 0) begin : g_first
      assign cur    = in_item;
      assign cur_rm = '0;
    end else begin : g_next
      assign cur    = st[k-1];
      assign cur_rm = rm[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh   = {cur_rm, cur.sq[2*W-1 -: 2]};
      trial    = {1'b0, cur.root, 2'b01};
      diff     = rem_sh - trial;
      take     = (rem_sh >= trial);
      nxt      = cur;
      nxt.sq   = {cur.sq[2*W-3:0], 2'b00};
      nxt.root = {cur.root[W-2:0], take};
      rm_next  = take ? diff[W:0] : rem_sh[W:0];
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else begin
        st[k] <= nxt;
      end
      rm[k] <= rm_next;
    end
  end

  assign out_item = st[SQ_STEPS-1];

endmodule

// File: design/va_div.sv
// Pipelined unsigned restoring divider, three lanes, one quotient bit per stage.
module va_div (
  input  logic                          clk,
  input  logic                          rst,
  input  va_pkg::item_t                 in_item,
  output va_pkg::item_t                 out_item,
  output logic [2:0][va_pkg::DIV_W-1:0] out_quo
);
  import va_pkg::*;

  typedef struct packed {
    logic [2:0][DIV_W-1:0] dv;
    logic [2:0][W-1:0]     rem;
    logic [W-1:0]          d;
  } dstate_t;

  item_t   prep_item;
  dstate_t prep_ds;
  dstate_t prep_next;
  item_t   st [DIV_W];
  dstate_t ds [DIV_W];

  // Operand preparation: magnitudes of the dividends and of the divisor.
  always_comb begin
    prep_next.d = (in_item.op == OP_DIV) ? mag_w(in_item.s) : in_item.root;
    for (int i = 0; i < 3; i++) begin
      prep_next.dv[i]  = {mag_w(in_item.a[i]), {FRAC_BITS{1'b0}}};
      prep_next.rem[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_item.valid <= 1'b0;
    end else begin
      prep_item <= in_item;
    end
    prep_ds <= prep_next;
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    item_t   cur;
    dstate_t cur_ds;
    dstate_t nxt_ds;

    if (k == 0) begin : g_first
      assign cur    = prep_item;
      assign cur_ds = prep_ds;
    end else begin : g_next
      assign cur    = st[k-1];
      assign cur_ds = ds[k-1];
    end

    // Shift in one dividend bit per lane and subtract the divisor when it fits.
    always_comb begin
      logic [W:0] rem_sh;
      logic [W:0] diff;
      logic       take;
      nxt_ds = cur_ds;
      for (int i = 0; i < 3; i++) begin
        rem_sh           = {cur_ds.rem[i], cur_ds.dv[i][DIV_W-1]};
        diff             = rem_sh - {1'b0, cur_ds.d};
        take             = (rem_sh >= {1'b0, cur_ds.d});
        nxt_ds.rem[i]    = take ? diff[W-1:0] : rem_sh[W-1:0];
        nxt_ds.dv[i]     = {cur_ds.dv[i][DIV_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else begin
        st[k] <= cur;
      end
      ds[k] <= nxt_ds;
    end
  end

  assign out_item = st[DIV_W-1];
  assign out_quo  = ds[DIV_W-1].dv;

endmodule

// File: design/vector3_arithmetic_unit.sv
// Top level of the three-component Q16.16 vector ALU.
//
// Usage: raise start for one cycle with operation, vectors A and B and
// scale_factor on the input ports; the beat is taken at a rising edge where
// start is high and busy is low. busy is high only during reset, so a new
// beat may be issued in every cycle.
// Each beat yields one result beat: r_x, r_y, r_z, scalar_out, is_equal and
// status are valid while done is high, for exactly one cycle.
// Every operation passes through every stage, and throughput is one beat
// per cycle. A beat passes through the input, multiply and combine stages,
// the 32-stage square-root pipeline (one root bit per stage), the divider
// setup stage, the 48-stage divider (one quotient bit per stage) and the
// output stage.
// Results come out in issue order. The receiver cannot hold results off, so
// there is no backpressure path anywhere in the pipeline.
// A synchronous reset drops every beat in flight and clears done.
module vector3_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  operation,
  input  logic signed [va_pkg::W-1:0] a_x,
  input  logic signed [va_pkg::W-1:0] a_y,
  input  logic signed [va_pkg::W-1:0] a_z,
  input  logic signed [va_pkg::W-1:0] b_x,
  input  logic signed [va_pkg::W-1:0] b_y,
  input  logic signed [va_pkg::W-1:0] b_z,
  input  logic signed [va_pkg::W-1:0] scale_factor,
  output logic                        done,
  output logic signed [va_pkg::W-1:0] r_x,
  output logic signed [va_pkg::W-1:0] r_y,
  output logic signed [va_pkg::W-1:0] r_z,
  output logic signed [va_pkg::W-1:0] scalar_out,
  output logic                        is_equal,
  output logic [1:0]                  status
);
  import va_pkg::*;

  localparam logic [DIV_W-1:0] Q_MAX = {{(DIV_W-W+1){1'b0}}, {(W-1){1'b1}}};

  logic accept;

  item_t             s0_item;
  logic [2:0][W-1:0] s0_b;

  item_t                 s1_item;
  logic signed [2*W-1:0] prod [6];

  item_t s2_item;
  item_t s2_next;

  item_t                 sq_item;
  item_t                 dv_item;
  logic [2:0][DIV_W-1:0] dv_quo;

  logic [2:0][W-1:0] fin_r;
  logic [W-1:0]      fin_scalar;
  logic              fin_eq;
  status_t           fin_status;

  assign busy   = rst;
  assign accept = start && !busy;

  // Input stage: capture the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_item.valid <= 1'b0;
    end else begin
      s0_item.valid <= accept;
    end
    s0_item.op     <= op_t'(operation);
    s0_item.a      <= {a_z, a_y, a_x};
    s0_item.s      <= scale_factor;
    s0_item.r      <= '0;
    s0_item.scalar <= '0;
    s0_item.eq     <= 1'b0;
    s0_item.sat    <= 1'b0;
    s0_item.sq     <= '0;
    s0_item.root   <= '0;
    s0_b           <= {b_z, b_y, b_x};
  end

  // Multiply stage: six products, plus add, subtract and equality.
  always_ff @(posedge clk) begin
    logic signed [W-1:0]   ma [6];
    logic signed [W-1:0]   mb [6];
    logic signed [2*W+1:0] sum;
    logic [W:0]            clamp;
    logic                  sat;
    item_t                 s1_next;
    for (int i = 0; i < 3; i++) begin
      ma[i] = $signed(s0_item.a[i]);
      case (s0_item.op)
        OP_DOT:   mb[i] = $signed(s0_b[i]);
        OP_SCALE: mb[i] = $signed(s0_item.s);
        default:  mb[i] = $signed(s0_item.a[i]);
      endcase
      ma[i+3] = '0;
      mb[i+3] = '0;
    end
    if (s0_item.op == OP_CROSS) begin
      ma[0] = $signed(s0_item.a[1]);  mb[0] = $signed(s0_b[2]);
      ma[1] = $signed(s0_item.a[2]);  mb[1] = $signed(s0_b[1]);
      ma[2] = $signed(s0_item.a[2]);  mb[2] = $signed(s0_b[0]);
      ma[3] = $signed(s0_item.a[0]);  mb[3] = $signed(s0_b[2]);
      ma[4] = $signed(s0_item.a[0]);  mb[4] = $signed(s0_b[1]);
      ma[5] = $signed(s0_item.a[1]);  mb[5] = $signed(s0_b[0]);
    end
    for (int k = 0; k < 6; k++) begin
      prod[k] <= ma[k] * mb[k];
    end

    s1_next = s0_item;
    sat     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s0_item.op == OP_SUB) begin
        sum = (2*W+2)'($signed(s0_item.a[i])) - (2*W+2)'($signed(s0_b[i]));
      end else begin
        sum = (2*W+2)'($signed(s0_item.a[i])) + (2*W+2)'($signed(s0_b[i]));
      end
      clamp = sat_w(sum);
      sat   = sat | clamp[W];
      s1_next.r[i] = clamp[W-1:0];
    end
    s1_next.sat = sat;
    s1_next.eq  = (s0_item.op == OP_EQUAL) && (s0_item.a == s0_b);

    if (rst) begin
      s1_item.valid <= 1'b0;
    end else begin
      s1_item <= s1_next;
    end
  end

  // Combine stage: cross differences, dot sum, scaling and the sum of squares.
  always_comb begin
    logic signed [2*W+1:0] wide;
    logic [W:0]            clamp;
    logic                  sat;
    wide         = '0;
    clamp        = '0;
    s2_next      = s1_item;
    s2_next.sq   = prod[0] + prod[1] + prod[2];
    s2_next.root = '0;
    sat          = 1'b0;
    case (s1_item.op)
      OP_ADD, OP_SUB: begin
        sat = s1_item.sat;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          wide  = ((2*W+2)'(prod[2*i]) - (2*W+2)'(prod[2*i+1])) >>> FRAC_BITS;
          clamp = sat_w(wide);
          sat   = sat | clamp[W];
          s2_next.r[i] = clamp[W-1:0];
        end
      end
      OP_DOT: begin
        wide  = ((2*W+2)'(prod[0]) + (2*W+2)'(prod[1]) + (2*W+2)'(prod[2]))
                >>> FRAC_BITS;
        clamp = sat_w(wide);
        sat   = clamp[W];
        s2_next.scalar = clamp[W-1:0];
        s2_next.r      = '0;
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          wide  = (2*W+2)'(prod[i]) >>> FRAC_BITS;
          clamp = sat_w(wide);
          sat   = sat | clamp[W];
          s2_next.r[i] = clamp[W-1:0];
        end
      end
      default: begin
        s2_next.r = '0;
      end
    endcase
    s2_next.sat = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_item.valid <= 1'b0;
    end else begin
      s2_item <= s2_next;
    end
  end

  va_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_item  (s2_item),
    .out_item (sq_item)
  );

  va_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_item  (sq_item),
    .out_item (dv_item),
    .out_quo  (dv_quo)
  );

  // Final stage: quotient signs, clamping and status.
  always_comb begin
    logic          neg;
    logic          sat;
    logic [W-1:0]  q_lo;
    neg        = 1'b0;
    q_lo       = '0;
    fin_r      = dv_item.r;
    fin_scalar = dv_item.scalar;
    fin_eq     = dv_item.eq;
    sat        = dv_item.sat;
    fin_status = ST_OK;
    case (dv_item.op)
      OP_MAG: begin
        sat        = dv_item.root[W-1];
        fin_scalar = dv_item.root[W-1] ? {1'b0, {(W-1){1'b1}}} : dv_item.root;
      end
      OP_DIV, OP_NORM: begin
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
          neg  = dv_item.a[i][W-1] ^ ((dv_item.op == OP_DIV) && dv_item.s[W-1]);
          q_lo = dv_quo[i][W-1:0];
          if (!neg && (dv_quo[i] > Q_MAX)) begin
            sat      = 1'b1;
            fin_r[i] = {1'b0, {(W-1){1'b1}}};
          end else if (neg && (dv_quo[i] > Q_MAX + 1'b1)) begin
            sat      = 1'b1;
            fin_r[i] = {1'b1, {(W-1){1'b0}}};
          end else begin
            fin_r[i] = neg ? (~q_lo + 1'b1) : q_lo;
          end
        end
        if ((dv_item.op == OP_DIV) && (dv_item.s == '0)) begin
          sat        = 1'b0;
          fin_status = ST_DIV0;
          for (int i = 0; i < 3; i++) begin
            if (dv_item.a[i][W-1]) begin
              fin_r[i] = {1'b1, {(W-1){1'b0}}};
            end else if (dv_item.a[i] != '0) begin
              fin_r[i] = {1'b0, {(W-1){1'b1}}};
            end else begin
              fin_r[i] = '0;
            end
          end
        end else if ((dv_item.op == OP_NORM) && (dv_item.root == '0)) begin
          sat        = 1'b0;
          fin_status = ST_ZERO;
          fin_r      = dv_item.a;
        end
      end
      OP_ADD, OP_SUB, OP_CROSS, OP_DOT, OP_SCALE, OP_EQUAL: begin
        sat = dv_item.sat;
      end
      default: begin
        sat        = 1'b0;
        fin_r      = '0;
        fin_scalar = '0;
        fin_eq     = 1'b0;
      end
    endcase
    if (sat && (fin_status == ST_OK)) begin
      fin_status = ST_SAT;
    end
  end

  // Output registers and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_item.valid;
    end
    r_x        <= fin_r[0];
    r_y        <= fin_r[1];
    r_z        <= fin_r[2];
    scalar_out <= fin_scalar;
    is_equal   <= fin_eq;
    status     <= fin_status;
  end

  // Every accepted beat comes out after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LATENCY+1) done)
    else $error("accepted beat did not produce a result on time");

  // Every result beat traces back to an accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY+1))
    else $error("result strobe without a matching input beat");

  // An equality hit carries no vector, no scalar and a clean status.
  assert property (@(posedge clk) disable iff (rst)
    done && is_equal |-> r_x == '0 && r_y == '0 && r_z == '0 &&
                         scalar_out == '0 && status == ST_OK)
    else $error("equality result carries stray data");

  // A divide by zero yields a vector result only.
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DIV0 |-> scalar_out == '0 && !is_equal)
    else $error("divide by zero result carries a scalar");

endmodule

// File: test/vector3_arithmetic_unit_tb.sv
// Self-checking testbench of the three-component Q16.16 vector ALU.
`timescale 1ns / 1ps

module vector3_arithmetic_unit_tb;
  import va_pkg::*;

  localparam int FRAC = FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sc;
    logic               eq;
    logic [1:0]         st;
  } vec_result_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [3:0] operation;
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
  logic done;
  logic signed [31:0] r_x, r_y, r_z, scalar_out;
  logic is_equal;
  logic [1:0] status;

  vec_result_t expected_results[$];
  int errors;
  int idle_cycles;
  bit timed_out;

  vector3_arithmetic_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .scale_factor(scale_factor), .done(done), .r_x(r_x), .r_y(r_y),
    .r_z(r_z), .scalar_out(scalar_out), .is_equal(is_equal), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp a wide value to 32 bits and note saturation.
  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Floor square root of a nonnegative wide value, bit by bit.
  function automatic logic [127:0] floor_root(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the expected result of one operation.
  function automatic vec_result_t vector_alu_result(input logic [3:0] op,
      input logic signed [31:0] ax, ay, az, bx, by, bz, s);
    vec_result_t res;
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] sf;
    logic signed [127:0] m;
    bit sat;
    res = '{0, 0, 0, 0, 1'b0, ST_OK};
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    sf = s;
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        res.rx = clamp_q(a[0] + b[0], sat);
        res.ry = clamp_q(a[1] + b[1], sat);
        res.rz = clamp_q(a[2] + b[2], sat);
      end
      OP_SUB: begin
        res.rx = clamp_q(a[0] - b[0], sat);
        res.ry = clamp_q(a[1] - b[1], sat);
        res.rz = clamp_q(a[2] - b[2], sat);
      end
      OP_CROSS: begin
        res.rx = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> FRAC, sat);
        res.ry = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> FRAC, sat);
        res.rz = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> FRAC, sat);
      end
      OP_DOT: begin
        res.sc = clamp_q((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC, sat);
      end
      OP_SCALE: begin
        res.rx = clamp_q((a[0] * sf) >>> FRAC, sat);
        res.ry = clamp_q((a[1] * sf) >>> FRAC, sat);
        res.rz = clamp_q((a[2] * sf) >>> FRAC, sat);
      end
      OP_DIV: begin
        if (sf == 0) begin
          // A zero divisor pins each component by its sign.
          res.rx = ax > 0 ? 32'sh7FFFFFFF : (ax < 0 ? 32'sh80000000 : 0);
          res.ry = ay > 0 ? 32'sh7FFFFFFF : (ay < 0 ? 32'sh80000000 : 0);
          res.rz = az > 0 ? 32'sh7FFFFFFF : (az < 0 ? 32'sh80000000 : 0);
          res.st = ST_DIV0;
        end else begin
          res.rx = clamp_q((a[0] <<< FRAC) / sf, sat);
          res.ry = clamp_q((a[1] <<< FRAC) / sf, sat);
          res.rz = clamp_q((a[2] <<< FRAC) / sf, sat);
        end
      end
      OP_MAG, OP_NORM: begin
        m = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (op == OP_MAG) begin
          res.sc = clamp_q(m, sat);
        end else if (m == 0) begin
          // A zero vector comes back as it went in.
          res.rx = ax; res.ry = ay; res.rz = az;
          res.st = ST_ZERO;
        end else begin
          res.rx = clamp_q((a[0] <<< FRAC) / m, sat);
          res.ry = clamp_q((a[1] <<< FRAC) / m, sat);
          res.rz = clamp_q((a[2] <<< FRAC) / m, sat);
        end
      end
      OP_EQUAL: res.eq = (ax == bx) && (ay == by) && (az == bz);
      default: ;
    endcase
    if (sat && res.st == ST_OK) res.st = ST_SAT;
    return res;
  endfunction

  // Send one beat, after a random gap unless no_gap is set, and queue its expected result.
  // The task returns at a falling edge with start still high; the next call
  // or the caller decides what start does next.
  task automatic send_vector_op(input logic [3:0] op,
      input logic signed [31:0] ax, ay, az, bx, by, bz, s, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    scale_factor <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.insert(expected_results.size(),
                            vector_alu_result(op, ax, ay, az, bx, by, bz, s));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 65535)) - 32768;
      2: return ($signed($urandom_range(0, 1023)) - 512) <<< 16;
      3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      4: return 0;
      default: return ($signed($urandom_range(0, 200000)) - 100000) <<< 4;
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [31:0] mx, mn;
    int op;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    for (op = 0; op < 9; op++) begin
      send_vector_op(4'(op), mx, mn, mx, mn, mx, mn, mx);
    end
    send_vector_op(OP_ADD, 32'sh00010000, -32'sh00020000, 0, 1, -1, 7, 0);
    send_vector_op(OP_DIV, 5, -5, 0, 0, 0, 0, 0);
    send_vector_op(OP_DIV, mx, mn, 1, 0, 0, 0, 1);
    send_vector_op(OP_DIV, 32'sh00030000, -7, 9, 0, 0, 0, -32'sh00020000);
    send_vector_op(OP_NORM, 0, 0, 0, 1, 2, 3, 4);
    send_vector_op(OP_NORM, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
    send_vector_op(OP_MAG, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
    send_vector_op(OP_EQUAL, 11, -12, 13, 11, -12, 13, 0);
    send_vector_op(OP_EQUAL, 11, -12, 13, 11, -12, 14, 0);
    send_vector_op(OP_SCALE, -1, 3, mn, 0, 0, 0, 32'sh00008000);
    send_vector_op(4'd9, 1, 2, 3, 4, 5, 6, 7);
    send_vector_op(4'd15, mx, mx, mx, mx, mx, mx, mx);
    send_vector_op(OP_CROSS, 32'sh00010000, 0, 0, 0, 32'sh00010000, 0, 0);
    send_vector_op(OP_DOT, -1, -1, -1, 1, 1, 1, 0);
  endtask

  task automatic test_random(input int count);
    logic signed [31:0] ax, ay, az;
    logic [3:0] op;
    int i;
    for (i = 0; i < count; i++) begin
      op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                      : 4'($urandom_range(0, 8));
      ax = rand_q(); ay = rand_q(); az = rand_q();
      if (op == OP_EQUAL && $urandom_range(0, 1)) begin
        send_vector_op(op, ax, ay, az, ax, ay, $urandom_range(0, 2) ? az : rand_q(),
                       0, i % 200 < 40);
      end else begin
        send_vector_op(op, ax, ay, az, rand_q(), rand_q(), rand_q(),
                       $urandom_range(0, 9) == 0 ? 0 : rand_q(), i % 200 < 40);
      end
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    vec_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no expectation waiting", $time);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (r_x !== exp_r.rx || r_y !== exp_r.ry || r_z !== exp_r.rz ||
            scalar_out !== exp_r.sc || is_equal !== exp_r.eq || status !== exp_r.st) begin
          $display("%0t: mismatch expected r=%h %h %h s=%h eq=%b st=%0d", $time,
                   exp_r.rx, exp_r.ry, exp_r.rz, exp_r.sc, exp_r.eq, exp_r.st);
          $display("%0t:          actual   r=%h %h %h s=%h eq=%b st=%0d", $time,
                   r_x, r_y, r_z, scalar_out, is_equal, status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat is taken on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    operation = '0;
    a_x = 0; a_y = 0; a_z = 0;
    b_x = 0; b_y = 0; b_z = 0;
    scale_factor = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_random(1800);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
